### rtl/lcsg_pkg.sv
// shared constants, types and the sine table builder for the chirp generator
package lcsg_pkg;

    localparam int TIME_W          = 32;
    localparam int COEFF_W         = 32;
    localparam int AMP_W           = 15;
    localparam int SAMPLE_W        = 16;
    localparam int SQ_W            = 2 * TIME_W;
    localparam int PH_W            = 57;
    localparam int PH_HI_W         = PH_W - 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int TAB_N           = 1 << SINE_TABLE_BITS;
    localparam int ENTRY_W         = 15;
    localparam int MAG_W           = 15;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 32;
    localparam int STAGES          = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COEFF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = CFG_IDX_W'(1);

    localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(65536);
    localparam logic [AMP_W-1:0]   AMP_RESET   = AMP_W'(16384);

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [ENTRY_W-1:0] t_tab [TAB_N];

    // shift-and-subtract long division, truncating, for the table build
    function automatic longint unsigned f_udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // quarter-wave midpoint table, taylor series to x^13 in q30
    function automatic t_tab f_build_tab();
        t_tab            tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned s;
        longint unsigned e;
        longint unsigned kk;
        for (int i = 0; i < TAB_N; i++) begin
            x  = (HALF_PI_Q30 * (64'd2 * longint'(i) + 64'd1)) >> (SINE_TABLE_BITS + 1);
            x2 = (x * x) >> 30;
            r  = Q30_ONE;
            for (int k = 13; k >= 3; k -= 2) begin
                kk = longint'(k);
                r  = Q30_ONE - f_udiv((x2 * r) >> 30, kk * (kk - 64'd1));
            end
            s = (x * r) >> 30;
            e = (s + (64'd1 << 14)) >> 15;
            if (e > 64'd32767) begin
                e = 64'd32767;
            end
            tab[i] = e[ENTRY_W-1:0];
        end
        return tab;
    endfunction

    localparam t_tab C_SINE_TAB = f_build_tab();

endpackage

### rtl/lcsg_ram.sv
// generic single-write, single-read ram with registered read data
module lcsg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lcsg_sine_rom.sv
// quarter-wave sine table: ram loaded from the constant table after reset
module lcsg_sine_rom
    import lcsg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_re,
    input  logic [SINE_TABLE_BITS-1:0] i_addr,
    output logic [ENTRY_W-1:0]         o_entry,
    output logic                       o_loaded
);

    logic [SINE_TABLE_BITS:0]   r_cnt;
    logic [SINE_TABLE_BITS:0]   n_cnt;
    logic                       r_we;
    logic [SINE_TABLE_BITS-1:0] r_waddr;
    logic [ENTRY_W-1:0]         r_wdata;

    assign n_cnt = r_cnt + (SINE_TABLE_BITS + 1)'(1);

    // load sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_we  <= 1'b0;
        end else begin
            r_we <= !r_cnt[SINE_TABLE_BITS];
            if (!r_cnt[SINE_TABLE_BITS]) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= r_cnt[SINE_TABLE_BITS-1:0];
        r_wdata <= C_SINE_TAB[r_cnt[SINE_TABLE_BITS-1:0]];
    end

    lcsg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TAB_N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_re    (i_re),
        .i_raddr (i_addr),
        .o_rdata (o_entry)
    );

    assign o_loaded = r_cnt[SINE_TABLE_BITS] && !r_we;

endmodule

### rtl/linear_chirp_sample_generator.sv
// linear chirp generator top level: squaring, phase, sine lookup and scaling pipeline
// an accepted item passes through the squaring, product, phase, table read, scaling and output registers
// throughput: one item per cycle; each stage stalls only when it holds an item that
// cannot move on, so bubbles are squeezed out while the output waits
// reset: synchronous active-low; clears the valid bits and restores the configuration
// registers to their defaults, then loads the sine table with input ready held low;
// configuration writes are taken throughout
module linear_chirp_sample_generator
    import lcsg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // input item channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [TIME_W-1:0]          i_sample_time,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_value
);

    // configuration registers
    logic [COEFF_W-1:0] r_coeff;
    logic [AMP_W-1:0]   r_amp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= COEFF_RESET;
            r_amp   <= AMP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SWEEP_COEFF: r_coeff <= i_cfg_data[COEFF_W-1:0];
                CFG_AMPLITUDE:   r_amp   <= i_cfg_data[AMP_W-1:0];
                default:         ;
            endcase
        end
    end

    // per-stage advance: a stage moves when it is empty or the next one moves
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_en;
    logic              w_loaded;
    logic              w_in_acc;

    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready = w_en[0] && w_loaded;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= w_in_acc;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: t squared, exact q24.40
    logic [SQ_W-1:0] r_t2;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_t2 <= SQ_W'(i_sample_time) * SQ_W'(i_sample_time);
        end
    end

    // stage 2: coeff times the low and high halves of t^2; only phase bits
    // below 57 matter, so the high product keeps 25 bits
    logic [PH_W-1:0]      r_plo;
    logic [PH_HI_W-1:0]   r_phi;
    logic [SQ_W-1:0]      w_plo_full;
    logic [2*PH_HI_W-1:0] w_phi_full;

    assign w_plo_full = SQ_W'(r_coeff) * SQ_W'(r_t2[31:0]);
    assign w_phi_full = (2*PH_HI_W)'(r_coeff[PH_HI_W-1:0])
                      * (2*PH_HI_W)'(r_t2[PH_W-1:32]);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_plo <= w_plo_full[PH_W-1:0];
            r_phi <= w_phi_full[PH_HI_W-1:0];
        end
    end

    // stage 3: phase modulo one turn, quadrant and mirrored table index
    logic [PH_HI_W-1:0]         w_ph_hi;
    logic [PH_W-1:0]            w_ph;
    logic [1:0]                 w_quad;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [SINE_TABLE_BITS-1:0] r_addr;
    logic                       r_neg3;

    assign w_ph_hi = r_plo[PH_W-1:32] + r_phi;
    assign w_ph    = {w_ph_hi, r_plo[31:0]};
    assign w_quad  = w_ph[PH_W-1 -: 2];
    // odd quadrants read the table backwards
    assign w_idx   = w_ph[PH_W-3 -: SINE_TABLE_BITS]
                   ^ {SINE_TABLE_BITS{w_quad[0]}};

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_addr <= w_idx;
            r_neg3 <= w_quad[1];
        end
    end

    // stage 4: table read, data registered inside the ram
    logic [ENTRY_W-1:0] w_entry;
    logic               r_neg4;

    lcsg_sine_rom u_sine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_re     (w_en[3]),
        .i_addr   (r_addr),
        .o_entry  (w_entry),
        .o_loaded (w_loaded)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_neg4 <= r_neg3;
        end
    end

    // stage 5: amplitude scaling, round half up on the magnitude, saturate
    logic [AMP_W+ENTRY_W:0] w_prod;
    logic [SAMPLE_W-1:0]    w_mag_raw;
    logic [MAG_W-1:0]       r_mag;
    logic                   r_neg5;

    assign w_prod    = (AMP_W+ENTRY_W+1)'(r_amp) * (AMP_W+ENTRY_W+1)'(w_entry)
                     + (AMP_W+ENTRY_W+1)'(1 << 14);
    assign w_mag_raw = w_prod[AMP_W+ENTRY_W -: SAMPLE_W];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_mag  <= w_mag_raw[SAMPLE_W-1] ? {MAG_W{1'b1}} : w_mag_raw[MAG_W-1:0];
            r_neg5 <= r_neg4;
        end
    end

    // stage 6: apply sign, output register
    logic [SAMPLE_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_out <= r_neg5 ? (SAMPLE_W'(0) - {1'b0, r_mag}) : {1'b0, r_mag};
        end
    end

    assign o_out_valid    = r_vld[STAGES-1];
    assign o_sample_value = r_out;

endmodule
